/* rtl/core/mexp_pkg.sv */
// Shared types for the modular exponentiation block: controller states and
// the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

   // width of every value field on the ports and in the configuration and result registers
   localparam int unsigned FIELD_W = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SQ_START,
      ST_MULT_START,
      ST_MUL_RUN,
      ST_MUL_END,
      ST_DONE
   } mexp_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture item, operands and exponent
      logic mul_begin;  // set up one modular multiplication
      logic sel_base;   // second operand is the base, else the running result
      logic mul_step;   // one multiplier bit
      logic commit;     // running result takes the product
      logic exp_shift;  // advance to the next exponent bit
      logic emit;       // present the result
   } mexp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err;        // value above modulus, or modulus zero
      logic mul_last;   // last multiplier bit in progress
      logic exp_bit;    // current exponent bit
      logic exp_last;   // current exponent bit is the final one
   } mexp_sts_type;

endpackage

`default_nettype wire

/* rtl/core/mexp_dp.sv */
// Datapath of the modular exponentiation block: operand registers, exponent
// shifter and the bit-serial modular multiplier with interleaved reduction.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_dp #(
   parameter int unsigned WIDTH    = 32,
   parameter int unsigned EXP_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mexp_pkg::mexp_cmd_type        cmd,
   output mexp_pkg::mexp_sts_type             sts,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  message_value,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  exponent,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  modulus,
   output logic                               rsp_valid,
   output logic [mexp_pkg::FIELD_W-1:0]       rsp_result_value,
   output logic                               rsp_error_flag
);

   localparam int unsigned MCW = $clog2(WIDTH);
   localparam int unsigned ECW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
   localparam int unsigned SW  = WIDTH + 3;

   logic [WIDTH-1:0]    n_ff, n_in;
   logic [WIDTH-1:0]    base_ff, base_in;
   logic [WIDTH-1:0]    r_ff, r_in;
   logic [WIDTH-1:0]    a_ff, a_in;
   logic [WIDTH-1:0]    b_ff, b_in;
   logic [WIDTH-1:0]    acc_ff, acc_in;
   logic [MCW-1:0]      mcnt_ff, mcnt_in;
   logic [EXP_BITS-1:0] e_ff, e_in;
   logic [ECW-1:0]      ecnt_ff, ecnt_in;
   logic                err_ff, err_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [mexp_pkg::FIELD_W-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_error_ff, rsp_error_in;

   logic [63:0]         x_wide, n_wide, e_wide, r_wide;
   logic [WIDTH-1:0]    x_load, n_load;
   logic [SW-1:0]       sum, sub1, sub2;
   logic [WIDTH-1:0]    step_res;

   // bring port values to the datapath widths
   assign x_wide = {32'b0, message_value};
   assign n_wide = {32'b0, modulus};
   assign e_wide = {32'b0, exponent};
   assign x_load = x_wide[WIDTH-1:0];
   assign n_load = n_wide[WIDTH-1:0];

   // one multiplier bit: 2*acc + (bit ? a : 0), then reduce from below 3n
   always_comb begin
      sum  = {2'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? {3'b0, a_ff} : '0);
      sub1 = sum - {3'b0, n_ff};
      sub2 = sum - {2'b0, n_ff, 1'b0};
      if (!sub2[SW-1]) begin
         step_res = sub2[WIDTH-1:0];
      end else if (!sub1[SW-1]) begin
         step_res = sub1[WIDTH-1:0];
      end else begin
         step_res = sum[WIDTH-1:0];
      end
   end

   // result word at field width
   always_comb begin
      r_wide = '0;
      r_wide[WIDTH-1:0] = r_ff;
   end

   // next values of the datapath registers
   always_comb begin
      n_in         = n_ff;
      base_in      = base_ff;
      r_in         = r_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      mcnt_in      = mcnt_ff;
      e_in         = e_ff;
      ecnt_in      = ecnt_ff;
      err_in       = err_ff;
      rsp_valid_in = cmd.emit;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      if (cmd.load) begin
         n_in    = n_load;
         base_in = (x_load == n_load) ? '0 : x_load;
         r_in    = (n_load == WIDTH'(1)) ? '0 : WIDTH'(1);
         e_in    = e_wide[EXP_BITS-1:0];
         ecnt_in = ECW'(EXP_BITS - 1);
         err_in  = (n_load == '0) || (x_load > n_load);
      end
      if (cmd.mul_begin) begin
         a_in    = r_ff;
         b_in    = cmd.sel_base ? base_ff : r_ff;
         acc_in  = '0;
         mcnt_in = MCW'(WIDTH - 1);
      end
      if (cmd.mul_step) begin
         acc_in  = step_res;
         b_in    = {b_ff[WIDTH-2:0], 1'b0};
         mcnt_in = mcnt_ff - MCW'(1);
      end
      if (cmd.commit) begin
         r_in = acc_ff;
      end
      if (cmd.exp_shift) begin
         e_in    = e_ff << 1;
         ecnt_in = ecnt_ff - ECW'(1);
      end
      if (cmd.emit) begin
         rsp_value_in = err_ff ? '0 : r_wide[mexp_pkg::FIELD_W-1:0];
         rsp_error_in = err_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      base_ff      <= base_in;
      r_ff         <= r_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      acc_ff       <= acc_in;
      mcnt_ff      <= mcnt_in;
      e_ff         <= e_in;
      ecnt_ff      <= ecnt_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.err      = err_ff;
   assign sts.mul_last = (mcnt_ff == '0);
   assign sts.exp_bit  = e_ff[EXP_BITS-1];
   assign sts.exp_last = (ecnt_ff == '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_error_flag   = rsp_error_ff;

   // partial product stays reduced after every multiplier bit
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.mul_step) && !err_ff |-> acc_ff < n_ff)
      else $error("partial product not below modulus");

   // running result stays reduced after each commit
   a_r_reduced: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.commit) && !err_ff |-> r_ff < n_ff)
      else $error("running result not below modulus");

endmodule

`default_nettype wire

/* rtl/core/mexp_ctrl.sv */
// Controller of the modular exponentiation block: walks the exponent bits
// and sequences square and multiply passes through the datapath.
// Depends on mexp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire mexp_pkg::mexp_sts_type  sts,
   output mexp_pkg::mexp_cmd_type       cmd
);

   mexp_pkg::mexp_state_type state_ff, state_in;
   logic                     mult_ff, mult_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
         mult_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mult_ff  <= mult_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      mult_in  = mult_ff;
      cmd      = '0;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_CHECK: begin
            state_in = sts.err ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQ_START;
         end
         mexp_pkg::ST_SQ_START: begin
            cmd.mul_begin = 1'b1;
            mult_in       = 1'b0;
            state_in      = mexp_pkg::ST_MUL_RUN;
         end
         mexp_pkg::ST_MULT_START: begin
            cmd.mul_begin = 1'b1;
            cmd.sel_base  = 1'b1;
            mult_in       = 1'b1;
            state_in      = mexp_pkg::ST_MUL_RUN;
         end
         mexp_pkg::ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_last) begin
               state_in = mexp_pkg::ST_MUL_END;
            end
         end
         mexp_pkg::ST_MUL_END: begin
            cmd.commit = 1'b1;
            if (!mult_ff && sts.exp_bit) begin
               state_in = mexp_pkg::ST_MULT_START;
            end else begin
               cmd.exp_shift = 1'b1;
               state_in = sts.exp_last ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQ_START;
            end
         end
         mexp_pkg::ST_DONE: begin
            cmd.emit = 1'b1;
            state_in = mexp_pkg::ST_IDLE;
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != mexp_pkg::ST_IDLE);

   // a multiplication setup is always followed by its first bit
   a_begin_step: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_begin |=> cmd.mul_step)
      else $error("multiplier setup not followed by a step");

endmodule

`default_nettype wire

/* rtl/core/modular_exponentiation.sv */
// Top level of the modular exponentiation block: configuration registers on
// an APB-style port, controller and datapath. Depends on mexp_pkg,
// mexp_ctrl and mexp_dp.
//
// Usage: write exponent (address 0) and modulus (address 4) while the block
// is idle. Raise start with req_message_value while busy is low; the item is
// taken at that edge. One result follows per item, on rsp_result_value and
// rsp_error_flag, marked by rsp_valid for exactly one cycle.
// All bits of the exponent's low EXP_BITS bits are scanned: each takes a
// squaring and each one bit a further multiplication, and every modular
// multiplication runs through the shared bit-serial multiplier at one
// operand bit per cycle, with a setup step before and a commit step after.
// A value above the modulus (or a zero modulus) skips the multiplications
// and is answered with error flag set and result zero. The next item may be
// started in the cycle its result shows.
// Reset sets both registers to 1 and idles the controller. The receiver
// cannot stall; a result not taken in its cycle is gone.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation #(
   parameter int unsigned WIDTH    = 32,
   parameter int unsigned EXP_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [mexp_pkg::FIELD_W-1:0]  req_message_value,
   output logic                               rsp_valid,
   output logic [mexp_pkg::FIELD_W-1:0]       rsp_result_value,
   output logic                               rsp_error_flag,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [2:0]                    paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic [mexp_pkg::FIELD_W-1:0] exponent_ff, exponent_in;
   logic [mexp_pkg::FIELD_W-1:0] modulus_ff, modulus_in;
   logic                         wr_en;
   mexp_pkg::mexp_cmd_type       cmd;
   mexp_pkg::mexp_sts_type       sts;

   // register write decode
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (wr_en) begin
         if (paddr[2]) begin
            modulus_in = pwdata;
         end else begin
            exponent_in = pwdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= mexp_pkg::FIELD_W'(1);
         modulus_ff  <= mexp_pkg::FIELD_W'(1);
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   assign prdata = paddr[2] ? modulus_ff : exponent_ff;
   assign pready = 1'b1;

   mexp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   mexp_dp #(
      .WIDTH    (WIDTH),
      .EXP_BITS (EXP_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .message_value    (req_message_value),
      .exponent         (exponent_ff),
      .modulus          (modulus_ff),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_error_flag   (rsp_error_flag)
   );

   // an error item always carries a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_result_value == '0)
      else $error("error item with nonzero result");

endmodule

`default_nettype wire
